>>> hdl/rccfd_pkg.sv
// Shared types and constants of the RC channel frame decoder.
package rccfd_pkg;

  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 9;
  localparam int RAW_W         = 11;
  localparam int VALUE_W       = 12;
  localparam int CH_W          = 4;
  localparam int PAYLOAD_BYTES = 22;
  localparam int PAY_AW        = $clog2(PAYLOAD_BYTES);
  localparam int ACC_W         = RAW_W - 1 + BYTE_W;
  localparam int ACC_CNT_W     = 5;
  localparam int MAG_W         = 22;
  localparam int QUO_W         = 11;
  localparam int RECIP_SHIFT   = 32;

  localparam logic [BYTE_W-1:0]  TYPE_CHANNELS = 8'h16;
  localparam logic [BYTE_W-1:0]  MIN_LENGTH    = 8'd24;
  localparam logic [COUNT_W-1:0] MIN_FRAME     = 9'd5;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 9'd259;
  localparam logic [COUNT_W-1:0] POS_LENGTH    = 9'd1;
  localparam logic [COUNT_W-1:0] POS_TYPE      = 9'd2;
  localparam logic [COUNT_W-1:0] POS_PAYLOAD   = 9'd3;
  localparam logic [COUNT_W-1:0] POS_PAY_END   = 9'd25;
  localparam logic [RAW_W:0]     RAW_OFFSET    = 12'd191;
  localparam logic [RAW_W-1:0]   SCALE_MUL     = 11'd1200;
  localparam logic [RAW_W-1:0]   SCALE_DIV     = 11'd1601;
  // floor(2^32 / 1601); quotient estimate is exact or one low
  localparam logic [MAG_W-1:0]   SCALE_RECIP   = 22'd2682677;
  localparam logic [VALUE_W-1:0] CENTER        = 12'd900;
  localparam logic [CH_W-1:0]    LAST_CH       = 4'd15;

  typedef struct packed {
    logic take_byte;
    logic dec_start;
    logic rd_issue;
    logic acc_load;
    logic ch_take;
    logic mul1;
    logic mul2;
    logic mul3;
    logic fix;
    logic ch_done;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic acc_ge11;
    logic last_ch;
  } sts_t;

endpackage

>>> hdl/rccfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rccfd_dp.sv
// Datapath: frame capture, payload store, bit unpacker and channel rescaler.
module rccfd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rccfd_pkg::cmd_t                     cmd,
  output rccfd_pkg::sts_t                     sts,
  input  logic [rccfd_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic                                in_frame_end,
  output logic [rccfd_pkg::CH_W-1:0]          out_channel_index,
  output logic [rccfd_pkg::VALUE_W-1:0]       out_channel_value,
  output logic                                out_last_channel
);
  import rccfd_pkg::*;

  logic [COUNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [COUNT_W-1:0]   count_inc;
  logic [BYTE_W-1:0]    length_r;
  logic [BYTE_W-1:0]    type_r;
  logic                 pay_we;
  logic [PAY_AW-1:0]    pay_waddr;
  logic [BYTE_W-1:0]    pay_rdata;
  logic [PAY_AW-1:0]    rd_addr_r;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_CNT_W-1:0] acc_cnt_r;
  logic [RAW_W-1:0]     raw_r;
  logic [CH_W-1:0]      ch_r;
  logic [RAW_W:0]       diff;
  logic [RAW_W-1:0]     mag;
  logic                 neg_r;
  logic [MAG_W-1:0]     dmag_r;
  logic [2*MAG_W-1:0]   recip_prod;
  logic [QUO_W-1:0]     q0_r;
  logic [MAG_W-1:0]     rem_r;
  logic [QUO_W-1:0]     quo;
  logic [CH_W-1:0]      idx_r;
  logic [VALUE_W-1:0]   value_r;
  logic                 last_r;

  // frame capture
  assign count_inc = (byte_count_r < COUNT_MAX) ? byte_count_r + 1'b1 : byte_count_r;
  assign byte_count_nxt = in_frame_end ? '0 : count_inc;
  assign pay_we    = cmd.take_byte && (byte_count_r >= POS_PAYLOAD) &&
                     (byte_count_r < POS_PAY_END);
  assign pay_waddr = PAY_AW'(byte_count_r - POS_PAYLOAD);

  // length and type are registered by the time a frame can reach five bytes
  assign sts.frame_ok = (count_inc >= MIN_FRAME) &&
                        ({1'b0, length_r} == count_inc - 2'd2) &&
                        (type_r == TYPE_CHANNELS) && (length_r >= MIN_LENGTH);
  assign sts.acc_ge11 = (acc_cnt_r >= ACC_CNT_W'(RAW_W));
  assign sts.last_ch  = (ch_r == LAST_CH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      length_r     <= '0;
      type_r       <= '0;
    end else if (cmd.take_byte) begin
      byte_count_r <= byte_count_nxt;
      if (byte_count_r == POS_LENGTH) begin
        length_r <= in_rx_byte;
      end
      if (byte_count_r == POS_TYPE) begin
        type_r <= in_rx_byte;
      end
    end
  end

  rccfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_BYTES)
  ) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (in_rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_addr_r),
    .rdata (pay_rdata)
  );

  // unpacker: bytes enter above the leftover bits, channels leave from the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      acc_cnt_r <= '0;
      ch_r      <= '0;
    end else begin
      if (cmd.dec_start) begin
        rd_addr_r <= '0;
        acc_cnt_r <= '0;
        ch_r      <= '0;
      end else begin
        if (cmd.rd_issue) begin
          rd_addr_r <= rd_addr_r + 1'b1;
        end
        if (cmd.acc_load) begin
          acc_cnt_r <= acc_cnt_r + ACC_CNT_W'(BYTE_W);
        end else if (cmd.ch_take) begin
          acc_cnt_r <= acc_cnt_r - ACC_CNT_W'(RAW_W);
        end
        if (cmd.ch_done) begin
          ch_r <= ch_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_start) begin
      acc_r <= '0;
    end else if (cmd.acc_load) begin
      acc_r <= acc_r | (ACC_W'(pay_rdata) << acc_cnt_r);
    end else if (cmd.ch_take) begin
      raw_r <= acc_r[RAW_W-1:0];
      acc_r <= acc_r >> RAW_W;
    end
  end

  // rescaler: sign and magnitude, reciprocal quotient, one correction step
  assign diff       = {1'b0, raw_r} - RAW_OFFSET;
  assign mag        = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign recip_prod = dmag_r * SCALE_RECIP;
  assign quo        = (rem_r >= MAG_W'(SCALE_DIV)) ? q0_r + 1'b1 : q0_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      neg_r  <= diff[RAW_W];
      dmag_r <= MAG_W'(mag * SCALE_MUL);
    end
    if (cmd.mul2) begin
      q0_r <= recip_prod[RECIP_SHIFT +: QUO_W];
    end
    if (cmd.mul3) begin
      rem_r <= dmag_r - MAG_W'(q0_r * SCALE_DIV);
    end
    if (cmd.fix) begin
      idx_r   <= ch_r;
      last_r  <= (ch_r == LAST_CH);
      value_r <= neg_r ? CENTER - VALUE_W'(quo) : CENTER + VALUE_W'(quo);
    end
  end

  assign out_channel_index = idx_r;
  assign out_channel_value = value_r;
  assign out_last_channel  = last_r;

endmodule

>>> hdl/rccfd_ctrl.sv
// Controller: sequences byte capture, payload unpacking and channel output.
module rccfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_frame_end,
  output logic            out_valid,
  input  logic            out_ready,
  output rccfd_pkg::cmd_t cmd,
  input  rccfd_pkg::sts_t sts
);
  import rccfd_pkg::*;

  typedef enum logic [3:0] {
    S_RECV,
    S_CHK,
    S_RD,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIX,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_RECV);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_RECV: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (in_frame_end && sts.frame_ok) begin
            cmd.dec_start = 1'b1;
            state_nxt     = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.acc_ge11) begin
          cmd.ch_take = 1'b1;
          state_nxt   = S_MUL1;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        cmd.acc_load = 1'b1;
        state_nxt    = S_CHK;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.ch_done = 1'b1;
          state_nxt   = sts.last_ch ? S_RECV : S_CHK;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/rc_channel_frame_decoder.sv
// Top level of the RC channel frame decoder.
// Frame bytes are taken one per cycle while in_ready is high, address byte
// first, with in_frame_end on the last byte. A frame of at least 5 bytes whose
// length byte equals the byte count minus 2, whose type byte is 0x16 and whose
// length byte is at least 24 yields 16 transfers on the out_ channel, channel 0
// first, with out_last_channel on channel 15; any other frame yields nothing.
// No CRC or address check is made. After a passing frame the input is held off
// while one shared sequencer unpacks and rescales the channels: each payload
// byte is read through the payload RAM's one read port (22 bytes) in S_CHK,
// S_RD and S_LOAD, and each channel through S_MUL1, S_MUL2, S_MUL3, S_FIX and
// S_OUT of the three-multiply rescaler. A dropped frame never holds off input.
module rc_channel_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rccfd_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rccfd_pkg::CH_W-1:0]          out_channel_index,
  output logic [rccfd_pkg::VALUE_W-1:0]       out_channel_value,
  output logic                                out_last_channel
);
  import rccfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rccfd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  rccfd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_rx_byte        (in_rx_byte),
    .in_frame_end      (in_frame_end),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_channel  (out_last_channel)
  );

endmodule
